// ===== rtl/dual_mode_frequency_counter_unit_defines.svh =====
// Assertion macros for the dual-mode frequency counter.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef DUAL_MODE_FREQUENCY_COUNTER_UNIT_DEFINES_SVH
`define DUAL_MODE_FREQUENCY_COUNTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMFC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dmfc_pkg.sv =====
// Shared types and constants for the dual-mode frequency counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dmfc_pkg;

  localparam int ADDR_W   = 4;   // three 32-bit registers at 0x0, 0x4, 0x8
  localparam int DATA_W   = 32;
  localparam int GATE_W   = 19;
  localparam int TGT_W    = 32;
  localparam int RES_W    = 32;
  localparam int FRAC_W   = 8;   // Q24.8 result
  localparam int QSAT_SH  = RES_W - FRAC_W;  // integer part limit is 2^24
  localparam int MS_PER_S = 1000;

  localparam logic [GATE_W-1:0] GATE_RST = GATE_W'(1000);
  localparam logic [TGT_W-1:0]  TGT_RST  = TGT_W'(1000);

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_GATE   = 2'd1,
    REG_TARGET = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_RUN   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CS_COUNT = 2'd0,
    CS_MUL   = 2'd1,
    CS_DIV   = 2'd2
  } ctl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE = 2'd0,
    DV_CHK  = 2'd1,
    DV_RUN  = 2'd2,
    DV_DONE = 2'd3
  } div_state_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

// ===== rtl/dmfc_meas.sv =====
// Edge detector, phase tracking and tick/edge counters of the frequency counter.
// Depends on dmfc_pkg.
`timescale 1ns / 1ps

module dmfc_meas import dmfc_pkg::*; #(
  parameter int COUNT_WIDTH = 32,
  parameter int GP_W        = 46
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   level,
  input  logic                   start,
  input  logic                   stop,
  input  logic                   mode,
  input  logic [GP_W-1:0]        gate_prod,
  input  logic [TGT_W-1:0]       target,
  output logic                   fin,
  output logic [COUNT_WIDTH-1:0] fin_edges,
  output logic [COUNT_WIDTH-1:0] fin_ticks
);

  localparam int SC_W = COUNT_WIDTH + 10;
  localparam int CG_W = (SC_W > GP_W) ? SC_W : GP_W;
  localparam int CE_W = (COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [SC_W-1:0] SC_BASE = SC_W'(MS_PER_S - 1);
  localparam logic [SC_W-1:0] SC_STEP = SC_W'(MS_PER_S);

  phase_t                 phase_r, phase_nxt;
  logic                   prev_r;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0] edge_r, edge_nxt;
  logic [SC_W-1:0]        sc_r, sc_nxt;     // 1000 * ticks + 999
  logic                   rise, t_inc, gate_hit, tgt_hit, run_hit;
  logic [COUNT_WIDTH-1:0] t_run, e_run;
  logic [SC_W-1:0]        sc_run;

  assign rise   = level & ~prev_r;
  assign t_inc  = (tick_r != CNT_MAX);
  assign t_run  = t_inc ? tick_r + 1'b1 : tick_r;
  assign sc_run = t_inc ? sc_r + SC_STEP : sc_r;
  assign e_run  = (rise && (edge_r != CNT_MAX)) ? edge_r + 1'b1 : edge_r;

  // ticks >= floor(P/1000) is the same as P <= 1000*ticks + 999
  assign gate_hit = (t_run == CNT_MAX) || (CG_W'(gate_prod) <= CG_W'(sc_run));
  assign tgt_hit  = (CE_W'(e_run) >= CE_W'(target));
  assign run_hit  = mode ? tgt_hit : gate_hit;

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      priority if (stop) begin
        phase_nxt = PH_IDLE;
      end else if (start) begin
        phase_nxt = PH_ARMED;
      end else begin
        unique case (phase_r)
          PH_ARMED: if (rise) phase_nxt = PH_RUN;
          PH_RUN:   if (run_hit) phase_nxt = PH_IDLE;
          default:  phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    tick_nxt = tick_r;
    edge_nxt = edge_r;
    sc_nxt   = sc_r;
    if (step && !stop) begin
      if (start || ((phase_r == PH_ARMED) && rise)) begin
        tick_nxt = '0;
        edge_nxt = '0;
        sc_nxt   = SC_BASE;
      end else if (phase_r == PH_RUN) begin
        tick_nxt = t_run;
        edge_nxt = e_run;
        sc_nxt   = sc_run;
      end
    end
  end

  always_comb begin
    fin       = step && !stop && !start && (phase_r == PH_RUN) && run_hit;
    fin_edges = e_run;
    fin_ticks = t_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prev_r  <= 1'b0;
      tick_r  <= '0;
      edge_r  <= '0;
      sc_r    <= SC_BASE;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      edge_r  <= edge_nxt;
      sc_r    <= sc_nxt;
      if (step) prev_r <= level;
    end
  end

endmodule

// ===== rtl/dmfc_div.sv =====
// Shared restoring divider: floor(num * 256 / den) as saturating Q24.8.
// One compare-subtract per cycle; depends on dmfc_pkg.
`timescale 1ns / 1ps

module dmfc_div import dmfc_pkg::*; #(
  parameter int NUM_W = 59,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             ack,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_stat_t        stat,
  output logic [RES_W-1:0] quo
);

  localparam int CMP_W  = (NUM_W > DEN_W + QSAT_SH) ? NUM_W : DEN_W + QSAT_SH;
  localparam int STEP_W = $clog2(RES_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RES_W - 1);

  div_state_t        st_r, st_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r, rem_r;
  logic [RES_W-1:0]  quo_r;
  logic              sat_r;
  logic [STEP_W-1:0] step_r;
  logic [CMP_W-1:0]  num_x, den_x;
  logic              over, ge;
  logic [DEN_W:0]    trial, den_t, diff;

  assign num_x = CMP_W'(num_r);
  assign den_x = CMP_W'(den_r) << QSAT_SH;
  assign over  = (num_x >= den_x);
  // quo_r doubles as the shift register of remaining dividend bits
  assign trial = {rem_r, quo_r[RES_W-1]};
  assign den_t = {1'b0, den_r};
  assign ge    = (trial >= den_t);
  assign diff  = trial - den_t;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DV_IDLE: if (start) st_nxt = DV_CHK;
      DV_CHK:  st_nxt = over ? DV_DONE : DV_RUN;
      DV_RUN:  if (step_r == LAST_STEP) st_nxt = DV_DONE;
      DV_DONE: if (ack) st_nxt = DV_IDLE;
      default: st_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    stat.done = (st_r == DV_DONE);
    stat.sat  = sat_r;
    quo       = quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      DV_IDLE: begin
        if (start) begin
          num_r <= num;
          den_r <= den;
        end
      end
      DV_CHK: begin
        sat_r  <= over;
        step_r <= '0;
        if (over) begin
          quo_r <= '1;
        end else begin
          rem_r <= num_x[QSAT_SH +: DEN_W];
          quo_r <= {num_x[QSAT_SH-1:0], {FRAC_W{1'b0}}};
        end
      end
      DV_RUN: begin
        rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_r  <= {quo_r[RES_W-2:0], ge};
        step_r <= step_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/dual_mode_frequency_counter_unit.sv =====
// Top level of the dual-mode (gate / reciprocal) frequency counter.
// Uses dmfc_pkg, dmfc_meas, dmfc_div and the assertion macro header.
//
//   port group   handshake             contents
//   in_*         in_valid / in_ready   signal_level, start_cmd, stop_cmd (one tick)
//   out_*        out_valid / out_ready freq_q8 (Q24.8 Hz), raw_value, saturated
//   APB          psel/penable/pwrite   measure_mode @0x0, gate_ms @0x4, edge_target @0x8
//
// A tick that does not finish a measurement leaves in_ready high.
// A finishing tick drops in_ready through one multiply, one range check,
// 32 restoring divide steps and the hand-off, with the divide steps skipped
// when the result saturates.
// A full output register stretches the hand-off until out_ready takes it.
// Reset (synchronous, rst_n low) clears phase, counters and out_valid and loads the config defaults.
`timescale 1ns / 1ps
`include "dual_mode_frequency_counter_unit_defines.svh"

module dual_mode_frequency_counter_unit import dmfc_pkg::*; #(
  parameter int TICK_HZ     = 16000000,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_signal_level,
  input  logic              in_start_cmd,
  input  logic              in_stop_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RES_W-1:0]  out_freq_q8,
  output logic [RES_W-1:0]  out_raw_value,
  output logic              out_saturated,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int TICK_W = $clog2(TICK_HZ + 1);
  localparam int GP_W   = GATE_W + TICK_W;
  localparam int DEN_W  = (COUNT_WIDTH > GATE_W) ? COUNT_WIDTH : GATE_W;
  localparam int A_W    = (COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W;
  localparam int NG_W   = COUNT_WIDTH + 10;
  localparam int NR_W   = TGT_W + TICK_W;
  localparam int NUM_W  = (NG_W > NR_W) ? NG_W : NR_W;
  localparam int RX_W   = ((COUNT_WIDTH > RES_W) ? COUNT_WIDTH : RES_W) + 1;
  localparam longint GP_RST_L = longint'(GATE_RST) * longint'(TICK_HZ);
  localparam logic [GP_W-1:0] GP_RST = GP_W'(GP_RST_L);

  // ---------------------------------------------------------------- config
  logic              mode_r;
  logic [GATE_W-1:0] gate_ms_r;
  logic [TGT_W-1:0]  target_r;
  logic [GP_W-1:0]   gate_prod_r;   // gate_ms (zero read as one) * TICK_HZ
  logic              cfg_wr;
  reg_idx_t          reg_idx;
  logic [GATE_W-1:0] wr_gate, wr_gate_eff, gate_eff;
  logic [TGT_W-1:0]  tgt_eff;
  logic [GP_W-1:0]   wr_prod;

  assign pready      = 1'b1;
  assign cfg_wr      = psel & penable & pwrite & pready;
  assign reg_idx     = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_gate     = pwdata[GATE_W-1:0];
  assign wr_gate_eff = (wr_gate == '0) ? GATE_W'(1) : wr_gate;
  // Precompute the gate length product on the write so ticks compare without a divide
  assign wr_prod     = GP_W'(wr_gate_eff) * GP_W'(TICK_HZ);
  assign gate_eff    = (gate_ms_r == '0) ? GATE_W'(1) : gate_ms_r;
  assign tgt_eff     = (target_r == '0) ? TGT_W'(1) : target_r;

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = DATA_W'(mode_r);
      REG_GATE:   prdata = DATA_W'(gate_ms_r);
      REG_TARGET: prdata = DATA_W'(target_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      gate_ms_r   <= GATE_RST;
      target_r    <= TGT_RST;
      gate_prod_r <= GP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE: mode_r <= pwdata[0];
        REG_GATE: begin
          gate_ms_r   <= wr_gate;
          gate_prod_r <= wr_prod;
        end
        REG_TARGET: target_r <= pwdata[TGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- counting
  logic                   in_step, meas_fin;
  logic [COUNT_WIDTH-1:0] fin_edges, fin_ticks;

  assign in_step = in_valid & in_ready;

  dmfc_meas #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .GP_W        (GP_W)
  ) u_meas (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_step),
    .level     (in_signal_level),
    .start     (in_start_cmd),
    .stop      (in_stop_cmd),
    .mode      (mode_r),
    .gate_prod (gate_prod_r),
    .target    (tgt_eff),
    .fin       (meas_fin),
    .fin_edges (fin_edges),
    .fin_ticks (fin_ticks)
  );

  // ---------------------------------------------------------------- operands
  // Latch everything the result needs on the finishing tick; the config is
  // free to change afterwards.
  logic              opr_mode_r;
  logic [A_W-1:0]    opr_val_r;
  logic [DEN_W-1:0]  opr_den_r;
  logic [RES_W-1:0]  opr_raw_r;
  logic [COUNT_WIDTH-1:0] raw_sel;
  logic [RX_W-1:0]   raw_x;

  assign raw_sel = mode_r ? fin_ticks : fin_edges;
  assign raw_x   = RX_W'(raw_sel);

  always_ff @(posedge clk) begin
    if (in_step && meas_fin) begin
      opr_mode_r <= mode_r;
      opr_val_r  <= mode_r ? A_W'(tgt_eff) : A_W'(fin_edges);
      opr_den_r  <= mode_r ? DEN_W'(fin_ticks) : DEN_W'(gate_eff);
      opr_raw_r  <= (|raw_x[RX_W-1:RES_W]) ? '1 : raw_x[RES_W-1:0];
    end
  end

  // Dividend: edges * 1000 in gate mode, target * TICK_HZ in reciprocal mode
  logic [NR_W-1:0]  prod_recip;
  logic [NUM_W-1:0] val_x, prod_gate, div_num;

  assign prod_recip = NR_W'(opr_val_r[TGT_W-1:0]) * NR_W'(TICK_HZ);
  assign val_x      = NUM_W'(opr_val_r);
  // 1000 = 1024 - 16 - 8
  assign prod_gate  = (val_x << 10) - (val_x << 4) - (val_x << 3);
  assign div_num    = opr_mode_r ? NUM_W'(prod_recip) : prod_gate;

  // ---------------------------------------------------------------- control
  ctl_state_t       ctl_st_r, ctl_st_nxt;
  logic             div_start, div_ack, out_free, out_load;
  div_stat_t        div_stat;
  logic [RES_W-1:0] div_quo;

  dmfc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .ack   (div_ack),
    .num   (div_num),
    .den   (opr_den_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  logic             out_valid_r;
  logic [RES_W-1:0] out_freq_r, out_raw_r;
  logic             out_sat_r;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    ctl_st_nxt = ctl_st_r;
    unique case (ctl_st_r)
      CS_COUNT: if (in_step && meas_fin) ctl_st_nxt = CS_MUL;
      CS_MUL:   ctl_st_nxt = CS_DIV;
      CS_DIV:   if (div_stat.done && out_free) ctl_st_nxt = CS_COUNT;
      default:  ctl_st_nxt = CS_COUNT;
    endcase
  end

  always_comb begin
    in_ready  = (ctl_st_r == CS_COUNT);
    div_start = (ctl_st_r == CS_MUL);
    out_load  = (ctl_st_r == CS_DIV) && div_stat.done && out_free;
    div_ack   = out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_st_r <= CS_COUNT;
    end else begin
      ctl_st_r <= ctl_st_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  // Hold the result until taken; drop valid on a handshake with no reload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_freq_r <= div_quo;
      out_raw_r  <= opr_raw_r;
      out_sat_r  <= div_stat.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_freq_q8   = out_freq_r;
  assign out_raw_value = out_raw_r;
  assign out_saturated = out_sat_r;

  // ---------------------------------------------------------------- checks
  `DMFC_ASSERT_NEXT(a_fin_starts_mul, in_step && meas_fin, ctl_st_r == CS_MUL, "finishing transaction did not start the divide")
  `DMFC_ASSERT_SAME(a_done_only_in_div, div_stat.done, ctl_st_r == CS_DIV, "divider done outside the divide state")
  `DMFC_ASSERT_SAME(a_sat_all_ones, out_valid && out_saturated, out_freq_q8 == '1, "saturated result is not all ones")

endmodule
